### design/rvr_pkg.sv
package rvr_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned NUM_REGS  = 32;

  // Input operation codes.
  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // funct7 encodings of the R-type group.
  localparam logic [6:0] FUNCT7_BASE = 7'b000_0000;
  localparam logic [6:0] FUNCT7_ALT  = 7'b010_0000;

  typedef enum logic [2:0] {
    F3_ADD_SUB = 3'd0,
    F3_SLL     = 3'd1,
    F3_SLT     = 3'd2,
    F3_SLTU    = 3'd3,
    F3_XOR     = 3'd4,
    F3_SRL_SRA = 3'd5,
    F3_OR      = 3'd6,
    F3_AND     = 3'd7
  } funct3_e;

  typedef struct packed {
    logic            legal;
    logic [XLEN-1:0] value;
  } alu_res_t;

  function automatic alu_res_t alu_exec(input logic [6:0]      funct7,
                                        input logic [2:0]      funct3,
                                        input logic [XLEN-1:0] a,
                                        input logic [XLEN-1:0] b);
    alu_res_t  r;
    logic [4:0] sh;
    r.legal = 1'b0;
    r.value = '0;
    sh      = b[4:0];
    if (funct7 == FUNCT7_BASE) begin
      r.legal = 1'b1;
      case (funct3_e'(funct3))
        F3_ADD_SUB: r.value = a + b;
        F3_SLL:     r.value = a << sh;
        F3_SLT:     r.value = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
        F3_SLTU:    r.value = {{(XLEN-1){1'b0}}, (a < b)};
        F3_XOR:     r.value = a ^ b;
        F3_SRL_SRA: r.value = a >> sh;
        F3_OR:      r.value = a | b;
        F3_AND:     r.value = a & b;
        default:    r.legal = 1'b0;
      endcase
    end else if (funct7 == FUNCT7_ALT) begin
      case (funct3_e'(funct3))
        F3_ADD_SUB: begin
          r.legal = 1'b1;
          r.value = a - b;
        end
        F3_SRL_SRA: begin
          r.legal = 1'b1;
          r.value = $unsigned($signed(a) >>> sh);
        end
        default: r.legal = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

### design/rv32i_rtype_execute.sv
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   operation_i, instruction_i, load_index_i, load_value_i
// output    out_valid_o / out_stall_i dest_index_o, dest_value_o, wrote_o, illegal_o
//
// One transaction per cycle while the output is not stalled. A transaction reads rs1 and
// rs2 from the register file memory at the accepting edge; when it leaves the execute
// stage it writes rd and its result is loaded into the output register at the same edge.
// Reset clears the per-entry valid bits, so every register reads as zero at once.
// A stalled output holds the executing transaction, which in turn stalls the input.
module rv32i_rtype_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] instruction_i,
  input  logic [4:0]  load_index_i,
  input  logic [31:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic        wrote_o,
  output logic        illegal_o
);

  localparam int unsigned XLEN = rvr_pkg::XLEN;
  localparam int unsigned AW   = rvr_pkg::REG_AW;

  // Register file memory and its valid bits.
  logic [XLEN-1:0]          mem [rvr_pkg::NUM_REGS];
  logic [rvr_pkg::NUM_REGS-1:0] valid_q;

  // Execute stage.
  logic            s1_valid_q;
  logic            s1_op_q;
  logic [31:0]     s1_instr_q;
  logic [AW-1:0]   s1_load_idx_q;
  logic [XLEN-1:0] s1_load_val_q;
  logic [XLEN-1:0] rd1_q, rd2_q;
  logic            rs1_vld_q, rs2_vld_q;
  logic            rs1_fwd_q, rs2_fwd_q;
  logic [XLEN-1:0] fwd_data_q;

  // Output register.
  logic            out_valid_q;
  logic [AW-1:0]   out_dest_q;
  logic [XLEN-1:0] out_value_q;
  logic            out_wrote_q;
  logic            out_illegal_q;

  logic            in_acc;
  logic            s1_move;
  logic [AW-1:0]   rs1, rs2;
  logic [XLEN-1:0] op_a, op_b;
  rvr_pkg::alu_res_t alu_r;
  logic [AW-1:0]   ex_dest;
  logic [XLEN-1:0] ex_value;
  logic            ex_wrote;
  logic            ex_illegal;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign rs1 = instruction_i[19:15];
  assign rs2 = instruction_i[24:20];

  // An operand comes from the write that retires in the same cycle it is read,
  // otherwise from the memory, and reads as zero while the entry was never written.
  always_comb begin
    if (rs1_fwd_q) begin
      op_a = fwd_data_q;
    end else if (rs1_vld_q) begin
      op_a = rd1_q;
    end else begin
      op_a = '0;
    end
    if (rs2_fwd_q) begin
      op_b = fwd_data_q;
    end else if (rs2_vld_q) begin
      op_b = rd2_q;
    end else begin
      op_b = '0;
    end
  end

  assign alu_r = rvr_pkg::alu_exec(s1_instr_q[31:25], s1_instr_q[14:12], op_a, op_b);

  always_comb begin
    if (s1_op_q == rvr_pkg::OP_LOAD) begin
      ex_dest    = s1_load_idx_q;
      ex_illegal = 1'b0;
      ex_wrote   = (s1_load_idx_q != '0);
      ex_value   = ex_wrote ? s1_load_val_q : '0;
    end else begin
      ex_dest    = s1_instr_q[11:7];
      ex_illegal = !alu_r.legal;
      ex_wrote   = alu_r.legal && (s1_instr_q[11:7] != '0);
      ex_value   = ex_wrote ? alu_r.value : '0;
    end
  end

  logic wr_en;
  assign wr_en = s1_move && ex_wrote;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ex_dest] <= ex_value;
    end
    if (in_acc) begin
      rd1_q <= mem[rs1];
      rd2_q <= mem[rs2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[ex_dest] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q       <= operation_i;
      s1_instr_q    <= instruction_i;
      s1_load_idx_q <= load_index_i;
      s1_load_val_q <= load_value_i;
      rs1_vld_q     <= valid_q[rs1];
      rs2_vld_q     <= valid_q[rs2];
      rs1_fwd_q     <= wr_en && (ex_dest == rs1);
      rs2_fwd_q     <= wr_en && (ex_dest == rs2);
      fwd_data_q    <= ex_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_dest_q    <= ex_dest;
      out_value_q   <= ex_value;
      out_wrote_q   <= ex_wrote;
      out_illegal_q <= ex_illegal;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_index_o = out_dest_q;
  assign dest_value_o = out_value_q;
  assign wrote_o      = out_wrote_q;
  assign illegal_o    = out_illegal_q;

endmodule
